// File: rtl/vdcp_pkg.sv
// Package: item types, command codes and constants of the video display CPU port.
`timescale 1ns / 1ps
`default_nettype none
package vdcp_pkg;

   localparam int unsigned PTR_BITS            = 14;
   localparam int unsigned VRAM_ADDR_BITS_DEF  = 14;
   localparam logic [4:0]  SPRITE_IDX_RESET    = 5'h1F;
   localparam logic [7:0]  READ_ZERO           = 8'h00;

   localparam logic [2:0] CMD_STATUS     = 3'd0;
   localparam logic [2:0] CMD_DATA_READ  = 3'd1;
   localparam logic [2:0] CMD_DATA_WRITE = 3'd2;
   localparam logic [2:0] CMD_CTRL_WRITE = 3'd3;
   localparam logic [2:0] CMD_EVENT      = 3'd4;

   localparam logic [2:0] REG_MODE0  = 3'd0;
   localparam logic [2:0] REG_MODE1  = 3'd1;
   localparam logic [2:0] REG_NAME   = 3'd2;
   localparam logic [2:0] REG_COLOR  = 3'd3;
   localparam logic [2:0] REG_BG_PAT = 3'd4;
   localparam logic [2:0] REG_ATTR   = 3'd5;
   localparam logic [2:0] REG_SP_PAT = 3'd6;
   localparam logic [2:0] REG_COLORS = 3'd7;

   typedef struct packed {
      logic [2:0] cmd;
      logic [7:0] write_byte;
      logic [4:0] event_sprite_index;
      logic       event_collision;
      logic       event_overflow;
      logic       event_frame;
   } req_type;

   typedef struct packed {
      logic [7:0]          read_data;
      logic                irq_line;
      logic [8:0]          mode_and_enables;
      logic [3:0]          name_table_base;
      logic [7:0]          color_table_base;
      logic [2:0]          bg_pattern_base;
      logic [6:0]          sprite_attr_base;
      logic [2:0]          sprite_pattern_base;
      logic [3:0]          backdrop_color;
      logic [3:0]          text_color;
      logic [PTR_BITS-1:0] vram_pointer;
      logic                latch_phase;
   } rsp_type;

   typedef struct packed {
      logic step;
      logic load_ra;
   } ctrl_cmd_type;

   typedef struct packed {
      logic ra_req;
   } dp_status_type;

endpackage
`default_nettype wire

// File: rtl/vdcp_ctrl.sv
// Controller: accepts items, sequences the read-ahead load and strobes results.
`timescale 1ns / 1ps
`default_nettype none
module vdcp_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   output logic                        rsp_valid,
   input  wire vdcp_pkg::dp_status_type status,
   output vdcp_pkg::ctrl_cmd_type      cmd
);

   typedef enum logic {
      ST_IDLE,
      ST_LOAD
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      load_ra_ff;
   logic      load_ra_in;
   logic      rsp_valid_ff;
   logic      step;

   assign busy      = reset | (state_ff == ST_LOAD);
   assign step      = start & ~busy;
   assign rsp_valid = rsp_valid_ff;

   assign cmd.step    = step;
   assign cmd.load_ra = (state_ff == ST_LOAD) & load_ra_ff;

   always_comb begin
      state_in   = state_ff;
      load_ra_in = load_ra_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (step) begin
               state_in   = ST_LOAD;
               load_ra_in = status.ra_req;
            end
         end
         ST_LOAD: begin
            state_in   = ST_IDLE;
            load_ra_in = 1'b0;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         load_ra_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         load_ra_ff   <= load_ra_in;
         rsp_valid_ff <= step;
      end
   end

endmodule
`default_nettype wire

// File: rtl/vdcp_datapath.sv
// Datapath: video memory, control latch, mode and table registers, status flags.
`timescale 1ns / 1ps
`default_nettype none
module vdcp_datapath #(
   parameter int unsigned VRAM_ADDR_BITS = vdcp_pkg::VRAM_ADDR_BITS_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire vdcp_pkg::req_type       req,
   input  wire vdcp_pkg::ctrl_cmd_type  cmd,
   output vdcp_pkg::dp_status_type      status,
   output vdcp_pkg::rsp_type            rsp
);

   localparam int unsigned MemDepth = 1 << VRAM_ADDR_BITS;
   localparam int unsigned PtrBits  = vdcp_pkg::PTR_BITS;

   logic [7:0]  mem [MemDepth];
   logic [7:0]  mem_q_ff;
   logic [VRAM_ADDR_BITS-1:0] mem_idx;
   logic [PtrBits-1:0] mem_addr;
   logic        mem_we;

   logic [15:0] word_ff, word_in;
   logic        pend_ff, pend_in;
   logic [4:0]  idx_ff, idx_in;
   logic [2:0]  flags_ff, flags_in;
   logic [8:0]  mode_ff, mode_in;
   logic [3:0]  name_ff, name_in;
   logic [7:0]  color_ff, color_in;
   logic [2:0]  bgpat_ff, bgpat_in;
   logic [6:0]  attr_ff, attr_in;
   logic [2:0]  sppat_ff, sppat_in;
   logic [3:0]  back_ff, back_in;
   logic [3:0]  text_ff, text_in;
   logic [7:0]  ra_ff;
   logic [7:0]  rd;
   logic        ra_req;
   logic [15:0] cw;
   logic [PtrBits-1:0] ptr, ptr_inc;
   vdcp_pkg::rsp_type rsp_ff, rsp_in;

   assign ptr     = word_ff[PtrBits-1:0];
   assign ptr_inc = ptr + PtrBits'(1);
   assign cw      = {req.write_byte, word_ff[7:0]};
   assign mem_idx = mem_addr[VRAM_ADDR_BITS-1:0];

   always_comb begin
      word_in  = word_ff;
      pend_in  = pend_ff;
      idx_in   = idx_ff;
      flags_in = flags_ff;
      mode_in  = mode_ff;
      name_in  = name_ff;
      color_in = color_ff;
      bgpat_in = bgpat_ff;
      attr_in  = attr_ff;
      sppat_in = sppat_ff;
      back_in  = back_ff;
      text_in  = text_ff;
      rd       = vdcp_pkg::READ_ZERO;
      ra_req   = 1'b0;
      mem_we   = 1'b0;
      mem_addr = ptr;
      unique case (req.cmd)
         vdcp_pkg::CMD_STATUS: begin
            pend_in  = 1'b0;
            rd       = {flags_ff, idx_ff};
            idx_in   = vdcp_pkg::SPRITE_IDX_RESET;
            flags_in = 3'b000;
         end
         vdcp_pkg::CMD_DATA_READ: begin
            word_in[PtrBits-1:0] = ptr_inc;
            pend_in = 1'b0;
            rd      = ra_ff;
            ra_req  = 1'b1;
         end
         vdcp_pkg::CMD_DATA_WRITE: begin
            word_in[PtrBits-1:0] = ptr_inc;
            pend_in = 1'b0;
            mem_we  = 1'b1;
         end
         vdcp_pkg::CMD_CTRL_WRITE: begin
            if (!pend_ff) begin
               word_in[7:0] = req.write_byte;
               pend_in      = 1'b1;
            end else begin
               pend_in = 1'b0;
               word_in = cw;
               if (cw[15]) begin
                  unique case (cw[10:8])
                     vdcp_pkg::REG_MODE0: begin
                        mode_in[3] = cw[0];
                        mode_in[2] = cw[1];
                     end
                     vdcp_pkg::REG_MODE1: begin
                        mode_in[4] = cw[0];
                        mode_in[5] = cw[1];
                        mode_in[1] = cw[3];
                        mode_in[0] = cw[4];
                        mode_in[6] = cw[5];
                        mode_in[7] = cw[6];
                        mode_in[8] = cw[7];
                     end
                     vdcp_pkg::REG_NAME:   name_in  = cw[3:0];
                     vdcp_pkg::REG_COLOR:  color_in = cw[7:0];
                     vdcp_pkg::REG_BG_PAT: bgpat_in = cw[2:0];
                     vdcp_pkg::REG_ATTR:   attr_in  = cw[6:0];
                     vdcp_pkg::REG_SP_PAT: sppat_in = cw[2:0];
                     vdcp_pkg::REG_COLORS: begin
                        back_in = cw[3:0];
                        text_in = cw[7:4];
                     end
                     default: ;
                  endcase
               end else if (!cw[14]) begin
                  mem_addr = cw[PtrBits-1:0];
                  word_in[PtrBits-1:0] = cw[PtrBits-1:0] + PtrBits'(1);
                  ra_req   = 1'b1;
               end
            end
         end
         vdcp_pkg::CMD_EVENT: begin
            if (req.event_collision) flags_in[0] = 1'b1;
            if (req.event_overflow) begin
               flags_in[1] = 1'b1;
               idx_in      = req.event_sprite_index;
            end
            if (req.event_frame) flags_in[2] = 1'b1;
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_in.read_data           = rd;
      rsp_in.irq_line            = flags_in[2] & mode_in[6];
      rsp_in.mode_and_enables    = mode_in;
      rsp_in.name_table_base     = name_in;
      rsp_in.color_table_base    = color_in;
      rsp_in.bg_pattern_base     = bgpat_in;
      rsp_in.sprite_attr_base    = attr_in;
      rsp_in.sprite_pattern_base = sppat_in;
      rsp_in.backdrop_color      = back_in;
      rsp_in.text_color          = text_in;
      rsp_in.vram_pointer        = word_in[PtrBits-1:0];
      rsp_in.latch_phase         = pend_in;
   end

   assign status.ra_req = ra_req;
   assign rsp           = rsp_ff;

   always_ff @(posedge clock) begin
      if (cmd.step && mem_we) begin
         mem[mem_idx] <= req.write_byte;
      end
      mem_q_ff <= mem[mem_idx];
   end

   always_ff @(posedge clock) begin
      if (cmd.step) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff  <= '0;
         pend_ff  <= 1'b0;
         idx_ff   <= vdcp_pkg::SPRITE_IDX_RESET;
         flags_ff <= '0;
         mode_ff  <= '0;
         name_ff  <= '0;
         color_ff <= '0;
         bgpat_ff <= '0;
         attr_ff  <= '0;
         sppat_ff <= '0;
         back_ff  <= '0;
         text_ff  <= '0;
         ra_ff    <= '0;
      end else begin
         if (cmd.step) begin
            word_ff  <= word_in;
            pend_ff  <= pend_in;
            idx_ff   <= idx_in;
            flags_ff <= flags_in;
            mode_ff  <= mode_in;
            name_ff  <= name_in;
            color_ff <= color_in;
            bgpat_ff <= bgpat_in;
            attr_ff  <= attr_in;
            sppat_ff <= sppat_in;
            back_ff  <= back_in;
            text_ff  <= text_in;
         end
         if (cmd.load_ra) begin
            ra_ff <= mem_q_ff;
         end
      end
   end

endmodule
`default_nettype wire

// File: rtl/video_display_cpu_port.sv
// Top level: CPU port of the video display processor, controller plus datapath.
// rsp_valid strobes in the cycle after the item is accepted; the receiver
// cannot stall. A new item is accepted only while busy is low; busy is high for the cycle
// after each accept, while the registered memory read feeds the read-ahead byte.
// Synchronous reset holds busy high and clears registers, sprite index to 31;
// the video memory is not cleared and reads as garbage until written.
`timescale 1ns / 1ps
`default_nettype none
module video_display_cpu_port #(
   parameter int unsigned VRAM_ADDR_BITS = vdcp_pkg::VRAM_ADDR_BITS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire vdcp_pkg::req_type req_item,
   output logic                   rsp_valid,
   output vdcp_pkg::rsp_type      rsp_item
);

   vdcp_pkg::ctrl_cmd_type  ctrl_cmd;
   vdcp_pkg::dp_status_type dp_status;

   vdcp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .status    (dp_status),
      .cmd       (ctrl_cmd)
   );

   vdcp_datapath #(
      .VRAM_ADDR_BITS (VRAM_ADDR_BITS)
   ) u_datapath (
      .clock  (clock),
      .reset  (reset),
      .req    (req_item),
      .cmd    (ctrl_cmd),
      .status (dp_status),
      .rsp    (rsp_item)
   );

`ifndef SYNTHESIS
   a_accept_strobes: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && rsp_valid))
      else $error("accepted item did not produce a result strobe");

   a_strobe_from_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy))
      else $error("result strobe without an accepted item");

   a_busy_one_cycle: assert property (@(posedge clock) disable iff (reset)
      busy |=> !busy)
      else $error("busy held longer than one cycle");
`endif

endmodule
`default_nettype wire

// File: dv/testbench.sv
// Testbench for the video display CPU port: directed and random CPU accesses checked against a local model.
`timescale 1ns / 1ps
module testbench;
   import vdcp_pkg::*;

   localparam int         ITEMS         = 800;
   localparam int         STALL_LIMIT   = 1000;
   localparam int         DRAIN         = 4;
   localparam int         IRQ_EN_BIT    = 6;
   localparam int         VRAM_WORDS    = 1 << PTR_BITS;
   localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
   localparam logic [2:0] CMD_UNUSED_HI = 3'd7;
   // second control byte, bits 7:6
   localparam logic [1:0] SEL_ADDR_READ  = 2'b00;
   localparam logic [1:0] SEL_ADDR_WRITE = 2'b01;
   localparam logic       SEL_REG        = 1'b1;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    start     = 1'b0;
   req_type req_item  = '0;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_item;

   video_display_cpu_port dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_item(req_item),
      .rsp_valid(rsp_valid),
      .rsp_item(rsp_item)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // model of the port
   logic [7:0]  vram [0:VRAM_WORDS-1];
   bit          vram_written [0:VRAM_WORDS-1];
   logic [7:0]  ahead_byte = '0;
   logic [15:0] ctl_word   = '0;
   logic        ctl_half   = 1'b0;
   logic [4:0]  sprite_idx = SPRITE_IDX_RESET;
   logic        flag_coll  = 1'b0;
   logic        flag_ovf   = 1'b0;
   logic        flag_frame = 1'b0;
   rsp_type     regs_view  = '0;

   rsp_type     due_responses [$];
   req_type     dir_req [$];
   bit          dir_typed [$];
   rsp_type     dir_rsp [$];
   int          items_sent   = 0;
   int          mismatches   = 0;
   int          quiet_cycles = 0;
   bit          no_idle      = 1'b0;

   task automatic fetch_ahead();
      ahead_byte = vram[ctl_word[PTR_BITS-1:0]];
      ctl_word[PTR_BITS-1:0] = ctl_word[PTR_BITS-1:0] + 1'b1;
      ctl_half = 1'b0;
   endtask

   task automatic write_reg(input logic [2:0] sel, input logic [7:0] d);
      case (sel)
         REG_MODE0: begin
            regs_view.mode_and_enables[3] = d[0];
            regs_view.mode_and_enables[2] = d[1];
         end
         REG_MODE1: begin
            regs_view.mode_and_enables[4] = d[0];
            regs_view.mode_and_enables[5] = d[1];
            regs_view.mode_and_enables[1] = d[3];
            regs_view.mode_and_enables[0] = d[4];
            regs_view.mode_and_enables[6] = d[5];
            regs_view.mode_and_enables[7] = d[6];
            regs_view.mode_and_enables[8] = d[7];
         end
         REG_NAME:   regs_view.name_table_base     = d[3:0];
         REG_COLOR:  regs_view.color_table_base    = d;
         REG_BG_PAT: regs_view.bg_pattern_base     = d[2:0];
         REG_ATTR:   regs_view.sprite_attr_base    = d[6:0];
         REG_SP_PAT: regs_view.sprite_pattern_base = d[2:0];
         default: begin
            regs_view.backdrop_color = d[3:0];
            regs_view.text_color     = d[7:4];
         end
      endcase
   endtask

   task automatic cpu_access_result(input req_type r, output rsp_type o);
      logic [7:0] rd;
      rd = READ_ZERO;
      case (r.cmd)
         CMD_STATUS: begin
            rd = {flag_frame, flag_ovf, flag_coll, sprite_idx};
            ctl_half   = 1'b0;
            sprite_idx = SPRITE_IDX_RESET;
            flag_coll  = 1'b0;
            flag_ovf   = 1'b0;
            flag_frame = 1'b0;
         end
         CMD_DATA_READ: begin
            rd = ahead_byte;
            fetch_ahead();
         end
         CMD_DATA_WRITE: begin
            vram[ctl_word[PTR_BITS-1:0]] = r.write_byte;
            vram_written[ctl_word[PTR_BITS-1:0]] = 1'b1;
            ctl_word[PTR_BITS-1:0] = ctl_word[PTR_BITS-1:0] + 1'b1;
            ctl_half = 1'b0;
         end
         CMD_CTRL_WRITE: begin
            if (!ctl_half) begin
               ctl_word[7:0] = r.write_byte;
               ctl_half = 1'b1;
            end else begin
               ctl_word[15:8] = r.write_byte;
               ctl_half = 1'b0;
               if (ctl_word[15]) write_reg(ctl_word[10:8], ctl_word[7:0]);
               else if (!ctl_word[14]) fetch_ahead();
            end
         end
         CMD_EVENT: begin
            if (r.event_collision) flag_coll = 1'b1;
            if (r.event_overflow) begin
               flag_ovf   = 1'b1;
               sprite_idx = r.event_sprite_index;
            end
            if (r.event_frame) flag_frame = 1'b1;
         end
         default: ;
      endcase
      o              = regs_view;
      o.read_data    = rd;
      o.irq_line     = flag_frame & regs_view.mode_and_enables[IRQ_EN_BIT];
      o.vram_pointer = ctl_word[PTR_BITS-1:0];
      o.latch_phase  = ctl_half;
   endtask

   // never read a memory location that was not written
   function automatic req_type legalize(input req_type r);
      logic [PTR_BITS-1:0] target;
      target = {r.write_byte[5:0], ctl_word[7:0]};
      if (r.cmd == CMD_DATA_READ && !vram_written[ctl_word[PTR_BITS-1:0]])
         r.cmd = CMD_DATA_WRITE;
      if (r.cmd == CMD_CTRL_WRITE && ctl_half && r.write_byte[7:6] == SEL_ADDR_READ
          && !vram_written[target])
         r.write_byte[6] = 1'b1;
      return r;
   endfunction

   function automatic req_type random_req();
      logic [$bits(req_type)-1:0] raw;
      raw = $urandom;
      return raw;
   endfunction

   function automatic req_type mk_item(input logic [2:0] cmd, input logic [7:0] wb);
      req_type r;
      r            = random_req();
      r.cmd        = cmd;
      r.write_byte = wb;
      return r;
   endfunction

   function automatic rsp_type plain_rsp(input logic [7:0] rd, input logic [PTR_BITS-1:0] ptr,
                                         input logic half);
      rsp_type o;
      o              = '0;
      o.read_data    = rd;
      o.vram_pointer = ptr;
      o.latch_phase  = half;
      return o;
   endfunction

   function automatic void add_row(input req_type r, input bit typed, input rsp_type e);
      dir_req.push_back(r);
      dir_typed.push_back(typed);
      dir_rsp.push_back(e);
   endfunction

   function automatic int pick_gap();
      int p;
      p = $urandom_range(0, 99);
      if (p < 55) return 0;
      if (p < 85) return $urandom_range(1, 3);
      if (p < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   task automatic send_item(input req_type r, input bit typed, input rsp_type typed_rsp);
      rsp_type pred;
      int      gap;
      gap = no_idle ? 0 : pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         start    <= 1'b0;
         req_item <= random_req();
         repeat (gap) @(negedge clock);
      end
      start    <= 1'b1;
      req_item <= r;
      do @(posedge clock); while (busy !== 1'b0);
      cpu_access_result(r, pred);
      due_responses.push_back(typed ? typed_rsp : pred);
      items_sent++;
   endtask

   task automatic send_cpu(input req_type r);
      send_item(legalize(r), 1'b0, '0);
   endtask

   task automatic ctrl_pair(input logic [7:0] lo, input logic [7:0] hi);
      send_cpu(mk_item(CMD_CTRL_WRITE, lo));
      if ($urandom_range(0, 19) == 0) send_cpu(mk_item(CMD_DATA_READ, $urandom));
      send_cpu(mk_item(CMD_CTRL_WRITE, hi));
   endtask

   // set a write address, fill a few bytes, point back with read-ahead and read them
   task automatic vram_block();
      logic [PTR_BITS-1:0] base;
      int                  n;
      int                  p;
      p = $urandom_range(0, 9);
      if (p < 7) base = $urandom_range(0, 63);
      else if (p < 9) base = $urandom;
      else base = VRAM_WORDS - 1 - $urandom_range(0, 7);
      n = $urandom_range(1, 6);
      if (ctl_half) send_cpu(mk_item(CMD_STATUS, $urandom));
      ctrl_pair(base[7:0], {SEL_ADDR_WRITE, base[13:8]});
      repeat (n) send_cpu(mk_item(CMD_DATA_WRITE, $urandom));
      ctrl_pair(base[7:0], {SEL_ADDR_READ, base[13:8]});
      repeat (n + $urandom_range(0, 1)) send_cpu(mk_item(CMD_DATA_READ, $urandom));
   endtask

   function automatic void check_field(input string name, input logic [15:0] want,
                                       input logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (due_responses.size() == 0) begin
            $error("result with no item outstanding");
            mismatches++;
         end else begin
            want = due_responses.pop_front();
            check_field("read_data", want.read_data, rsp_item.read_data);
            check_field("irq_line", want.irq_line, rsp_item.irq_line);
            check_field("mode_and_enables", want.mode_and_enables, rsp_item.mode_and_enables);
            check_field("name_table_base", want.name_table_base, rsp_item.name_table_base);
            check_field("color_table_base", want.color_table_base, rsp_item.color_table_base);
            check_field("bg_pattern_base", want.bg_pattern_base, rsp_item.bg_pattern_base);
            check_field("sprite_attr_base", want.sprite_attr_base, rsp_item.sprite_attr_base);
            check_field("sprite_pattern_base", want.sprite_pattern_base,
                        rsp_item.sprite_pattern_base);
            check_field("backdrop_color", want.backdrop_color, rsp_item.backdrop_color);
            check_field("text_color", want.text_color, rsp_item.text_color);
            check_field("vram_pointer", want.vram_pointer, rsp_item.vram_pointer);
            check_field("latch_phase", want.latch_phase, rsp_item.latch_phase);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && busy === 1'b0) || rsp_valid === 1'b1) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      req_type r;
      int      pick;
      int      total;

      add_row(mk_item(CMD_STATUS, 8'h00), 1'b1, plain_rsp(8'h1F, 14'h0000, 1'b0));
      add_row(mk_item(CMD_CTRL_WRITE, 8'h00), 1'b1, plain_rsp(READ_ZERO, 14'h0000, 1'b1));
      add_row(mk_item(CMD_CTRL_WRITE, 8'h40), 1'b1, plain_rsp(READ_ZERO, 14'h0000, 1'b0));
      add_row(mk_item(CMD_DATA_WRITE, 8'hFF), 1'b1, plain_rsp(READ_ZERO, 14'h0001, 1'b0));
      add_row(mk_item(CMD_DATA_WRITE, 8'h00), 1'b1, plain_rsp(READ_ZERO, 14'h0002, 1'b0));
      add_row(mk_item(CMD_CTRL_WRITE, 8'hFF), 1'b1, plain_rsp(READ_ZERO, 14'h00FF, 1'b1));
      add_row(mk_item(CMD_CTRL_WRITE, 8'h7F), 1'b1, plain_rsp(READ_ZERO, 14'h3FFF, 1'b0));
      // write at the top address, pointer wraps
      add_row(mk_item(CMD_DATA_WRITE, 8'hA5), 1'b1, plain_rsp(READ_ZERO, 14'h0000, 1'b0));
      add_row(mk_item(CMD_CTRL_WRITE, 8'h00), 1'b0, '0);
      add_row(mk_item(CMD_CTRL_WRITE, {SEL_ADDR_READ, 6'h00}), 1'b0, '0);
      add_row(mk_item(CMD_DATA_READ, 8'h00), 1'b0, '0);
      add_row(mk_item(CMD_CTRL_WRITE, 8'hFF), 1'b0, '0);
      add_row(mk_item(CMD_CTRL_WRITE, {SEL_ADDR_READ, 6'h3F}), 1'b0, '0);
      add_row(mk_item(CMD_DATA_READ, 8'h00), 1'b0, '0);
      add_row(mk_item(CMD_CTRL_WRITE, 8'hFF), 1'b0, '0);
      add_row(mk_item(CMD_CTRL_WRITE, {SEL_REG, 4'h0, REG_MODE0}), 1'b0, '0);
      add_row(mk_item(CMD_CTRL_WRITE, 8'hFF), 1'b0, '0);
      add_row(mk_item(CMD_CTRL_WRITE, {SEL_REG, 4'h0, REG_MODE1}), 1'b0, '0);
      add_row(mk_item(CMD_CTRL_WRITE, 8'hFF), 1'b0, '0);
      add_row(mk_item(CMD_CTRL_WRITE, {SEL_REG, 4'h0, REG_COLORS}), 1'b0, '0);
      r = mk_item(CMD_EVENT, 8'h00);
      r.event_sprite_index = '0;
      r.event_collision    = 1'b1;
      r.event_overflow     = 1'b1;
      r.event_frame        = 1'b1;
      add_row(r, 1'b0, '0);
      r.event_sprite_index = 5'h15;
      r.event_collision    = 1'b0;
      r.event_overflow     = 1'b0;
      r.event_frame        = 1'b0;
      add_row(r, 1'b0, '0);
      add_row(mk_item(CMD_STATUS, 8'hFF), 1'b0, '0);
      add_row(mk_item(CMD_UNUSED_HI, 8'hFF), 1'b0, '0);

      repeat (7) @(negedge clock);
      reset <= 1'b0;

      foreach (dir_req[i]) send_item(dir_req[i], dir_typed[i], dir_rsp[i]);

      total = dir_req.size() + ITEMS;
      while (items_sent < total) begin
         if ($urandom_range(0, 63) == 0) no_idle = !no_idle;
         pick = $urandom_range(0, 99);
         if (pick < 35) vram_block();
         else if (pick < 50) ctrl_pair($urandom, {SEL_REG, 4'($urandom), 3'($urandom)});
         else if (pick < 60) send_cpu(mk_item(CMD_STATUS, $urandom));
         else if (pick < 75) send_cpu(mk_item(CMD_EVENT, $urandom));
         else if (pick < 85)
            send_cpu(mk_item($urandom_range(0, 1) ? CMD_DATA_READ : CMD_DATA_WRITE, $urandom));
         else if (pick < 90) send_cpu(mk_item(CMD_CTRL_WRITE, $urandom));
         else if (pick < 95)
            send_cpu(mk_item($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI), $urandom));
         else send_cpu(random_req());
      end

      @(negedge clock);
      start <= 1'b0;
      while (due_responses.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      if (mismatches == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end
endmodule

// File: files.f
rtl/vdcp_pkg.sv
rtl/vdcp_ctrl.sv
rtl/vdcp_datapath.sv
rtl/video_display_cpu_port.sv
dv/testbench.sv
